### hdl/stereo_phaser_chorus_insert_macros.svh
// Assertion macros shared by the phaser and chorus insert.
`ifndef STEREO_PHASER_CHORUS_INSERT_MACROS_SVH
`define STEREO_PHASER_CHORUS_INSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPCI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/spci_pkg.sv
// Shared types and constants for the stereo phaser and chorus insert.
`default_nettype none

package spci_pkg;

	// Widths
	localparam int SMP_W      = 18;   // port sample width
	localparam int SAT_W      = 16;   // clipped sample width
	localparam int ROW_W      = 2 * SAT_W; // one stereo row of the delay line
	localparam int APW        = 32;   // all-pass memory word
	localparam int XW         = 36;   // running sample inside a lane
	localparam int COEF_W     = 15;
	localparam int TRI_W      = 15;
	localparam int D8_W       = 18;   // 10.8 delay, integer part fits 10 bits here
	localparam int DEPTH_W    = 8;
	localparam int PHASE_W    = 32;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int AP_STAGES  = 4;
	localparam int STG_W      = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PH_DEPTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CH_DEPTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PH_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CH_STEP  = 3'd3;

	// Register reset values
	localparam logic [PHASE_W-1:0] PH_STEP_RST = 32'd197456;
	localparam logic [PHASE_W-1:0] CH_STEP_RST = 32'd105068;

	// LFO mapping: coefficient 0.15..0.85 in Q15, delay 441..771 frames in 10.8
	localparam logic [COEF_W-1:0] COEF_BASE  = 15'd4915;
	localparam logic [COEF_W-1:0] COEF_SWEEP = 15'd22938;
	localparam logic [D8_W-1:0]   DLY_BASE   = D8_W'(441 * 256);
	localparam logic [D8_W-1:0]   DLY_SWEEP  = D8_W'(330 * 256);

	// Clip limits
	localparam int SAT_HI = 32767;
	localparam int SAT_LO = -32768;

	// Per-cycle strobes from the sequencer to each lane
	typedef struct packed {
		logic             load;   // transaction accepted, take the sample
		logic             ap_a;   // all-pass: y = m - c*s
		logic             ap_b;   // all-pass: m = s + c*y
		logic             mix;    // blend phaser output by depth
		logic             tap0;   // first interpolation product
		logic             tap1;   // second product and sum
		logic             chmix;  // add chorus tap by depth
		logic [STG_W-1:0] stage;  // current all-pass stage
	} spci_ctrl_t;

	// Frame-wide values shared by both lanes
	typedef struct packed {
		logic               bypass;
		logic [COEF_W-1:0]  coef;
		logic [DEPTH_W-1:0] ph_depth;
		logic [DEPTH_W-1:0] ch_depth;
		logic [FRAC_W-1:0]  frac;
	} spci_prm_t;

endpackage

`default_nettype wire

### hdl/spci_lane.sv
// One channel lane: four all-pass stages, phaser mix, chorus interpolation and mix.
`default_nettype none

module spci_lane import spci_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire spci_ctrl_t               ctrl,
	input  wire spci_prm_t                prm,
	input  wire logic signed [SMP_W-1:0]  sample_in,
	input  wire logic signed [SAT_W-1:0]  tap_word,
	output logic signed [SAT_W-1:0]       sat_out,
	output logic signed [SMP_W-1:0]       result
);

	localparam int MP_W  = APW + DEPTH_W + 2;   // diff (33) x depth (9)
	localparam int TP_W  = SAT_W + FRAC_W + 2;  // sample x weight, with sum headroom
	localparam int CP_W  = TP_W - FRAC_W + DEPTH_W + 1;
	localparam logic signed [XW-1:0] X_MAX = XW'(SAT_HI);
	localparam logic signed [XW-1:0] X_MIN = XW'(SAT_LO);

	logic signed [SMP_W-1:0]  x_in_q;
	logic signed [XW-1:0]     x_q;
	logic signed [APW-1:0]    s_q;
	logic signed [APW-1:0]    y_q;
	logic signed [APW:0]      diff_q;
	logic signed [TP_W-1:0]   p0_q;
	logic signed [TP_W-1:0]   acc_q;
	logic signed [APW-1:0]    ap_mem_q [AP_STAGES];

	logic signed [APW-1:0]        ap_op;
	logic signed [APW+COEF_W:0]   ap_prod;
	logic signed [APW-1:0]        ap_shift;
	logic signed [MP_W-1:0]       mix_prod;
	logic signed [9:0]            tap_wt;
	logic signed [TP_W-1:0]       tp_prod;
	logic signed [CP_W-1:0]       ch_prod;

	// Shared all-pass multiplier: s in the first half of a stage, y in the second
	assign ap_op    = ctrl.ap_b ? y_q : s_q;
	assign ap_prod  = ap_op * $signed({1'b0, prm.coef});
	assign ap_shift = ap_prod[APW+14:15];

	// depth << 7 then >> 15 is the same floor as depth then >> 8
	assign mix_prod = diff_q * $signed({1'b0, prm.ph_depth});

	// Interpolation weight: 256 - frac for the older sample, frac for the newer
	assign tap_wt  = ctrl.tap0 ? $signed(10'd256 - {2'b00, prm.frac})
	                           : $signed({2'b00, prm.frac});
	assign tp_prod = tap_word * tap_wt;

	assign ch_prod = $signed(acc_q[TP_W-1:FRAC_W]) * $signed({1'b0, prm.ch_depth});

	// All-pass memory, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AP_STAGES; i++) begin
				ap_mem_q[i] <= '0;
			end
		end else if (ctrl.ap_b) begin
			ap_mem_q[ctrl.stage] <= s_q + ap_shift;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_in_q <= sample_in;
			x_q    <= {{(XW-SMP_W){sample_in[SMP_W-1]}}, sample_in};
			s_q    <= {{(APW-SMP_W){sample_in[SMP_W-1]}}, sample_in};
		end
		if (ctrl.ap_a) begin
			y_q <= ap_mem_q[ctrl.stage] - ap_shift;
		end
		if (ctrl.ap_b) begin
			s_q    <= y_q;
			diff_q <= $signed({y_q[APW-1], y_q})
			        - $signed({{(APW+1-SMP_W){x_in_q[SMP_W-1]}}, x_in_q});
		end
		if (ctrl.mix) begin
			x_q <= x_q + $signed({{(XW-(MP_W-DEPTH_W)){mix_prod[MP_W-1]}},
			                      mix_prod[MP_W-1:DEPTH_W]});
		end
		if (ctrl.tap0) begin
			p0_q <= tp_prod;
		end
		if (ctrl.tap1) begin
			acc_q <= p0_q + tp_prod;
		end
		if (ctrl.chmix) begin
			x_q <= x_q + $signed({{(XW-(CP_W-DEPTH_W)){ch_prod[CP_W-1]}},
			                      ch_prod[CP_W-1:DEPTH_W]});
		end
	end

	// Clip to 16 bits
	always_comb begin
		if (x_q > X_MAX) begin
			sat_out = SAT_W'(SAT_HI);
		end else if (x_q < X_MIN) begin
			sat_out = SAT_W'(SAT_LO);
		end else begin
			sat_out = x_q[SAT_W-1:0];
		end
	end

	// Bypassed frames return the input untouched
	assign result = prm.bypass ? x_in_q
	                           : {{(SMP_W-SAT_W){sat_out[SAT_W-1]}}, sat_out};

endmodule

`default_nettype wire

### hdl/spci_delay.sv
// Stereo delay line memory with a clearing sweep after reset.
`default_nettype none

module spci_delay import spci_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [ROW_W-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [ROW_W-1:0] rd_data,
	output logic                  clearing
);

	logic [ROW_W-1:0] mem [DEPTH];
	logic [ROW_W-1:0] rd_data_q;
	logic [AW-1:0]    clr_addr_q;
	logic             clearing_q;

	// Clear sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

### hdl/stereo_phaser_chorus_insert.sv
// Stereo phaser and chorus insert: sequencer, LFOs, registers and lane merge.
//
// Usage
//   Input channel (in_valid/in_stall) carries one stereo frame, left_in and
//   right_in. Output channel (out_valid/out_stall) returns one processed frame
//   per input frame, in order. Registers are written through cfg_wr_en,
//   cfg_index and cfg_data while no frame is in flight.
//   One frame at a time: the two channel lanes run the four all-pass stages as
//   two multiply steps each, then the phaser mix, then the chorus tap needs
//   two reads of the single read port plus interpolation and mix.
//   With both effects a frame runs setup, all-pass steps, phaser mix and chorus
//   steps; phaser only skips the chorus steps, chorus only the all-pass steps and
//   phaser mix; a bypassed frame (both depths zero) goes straight to the final state.
//   The next frame is accepted while a finished result still waits in the
//   output register; a stalled receiver holds the result there and the
//   sequencer waits in its final state until the register frees up.
//   After reset the delay line is swept to zero, one row per cycle, over all
//   DELAY_FRAMES rows; in_stall stays high during that sweep. Registers
//   return to their reset values and the LFO phases and write position to 0.
`default_nettype none
`include "stereo_phaser_chorus_insert_macros.svh"

module stereo_phaser_chorus_insert import spci_pkg::*; #(
	parameter int DELAY_FRAMES = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	// input frames
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [SMP_W-1:0] left_in,
	input  wire logic signed [SMP_W-1:0] right_in,
	// output frames
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [SMP_W-1:0]      left_out,
	output logic signed [SMP_W-1:0]      right_out
);

	localparam int AW   = $clog2(DELAY_FRAMES);
	localparam int RW   = AW + 9;
	localparam int SPAN = DELAY_FRAMES * 256;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_SETUP  = 10'b00_0000_0010,
		ST_AP_A   = 10'b00_0000_0100,
		ST_AP_B   = 10'b00_0000_1000,
		ST_MIX    = 10'b00_0001_0000,
		ST_CH_WR  = 10'b00_0010_0000,
		ST_CH_RD  = 10'b00_0100_0000,
		ST_CH_INT = 10'b00_1000_0000,
		ST_CH_MIX = 10'b01_0000_0000,
		ST_DONE   = 10'b10_0000_0000
	} spci_state_t;

	function automatic logic [TRI_W-1:0] tri_wave(input logic [PHASE_W-1:0] ph);
		// falling half mirrors: 65535 - t is the complement of the low bits
		return ph[PHASE_W-1] ? ~ph[PHASE_W-2:PHASE_W-1-TRI_W] : ph[PHASE_W-2:PHASE_W-1-TRI_W];
	endfunction

	spci_state_t state_q, state_d;

	logic [DEPTH_W-1:0] ph_depth_q, ch_depth_q;
	logic [PHASE_W-1:0] ph_step_q, ch_step_q;
	logic [PHASE_W-1:0] ph_phase_q, ch_phase_q;
	logic [AW-1:0]      pos_q;
	logic [STG_W-1:0]   stage_q;
	logic               bypass_q, do_ph_q, do_ch_q;
	logic [COEF_W-1:0]  coef_q;
	logic [D8_W-1:0]    d8_q;
	logic [AW-1:0]      i0_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               out_valid_q;
	logic signed [SMP_W-1:0] left_out_q, right_out_q;

	logic               in_accept, out_load, pos_adv, bypass_w, clearing;
	logic [TRI_W-1:0]   tri_ph, tri_ch;
	logic [2*TRI_W-1:0] cprod;
	logic [PHASE_W-1:0] dprod;
	logic [COEF_W-1:0]  coef_w;
	logic [D8_W-1:0]    d8_w;
	logic [RW-1:0]      rp_raw, rp;
	logic [AW-1:0]      i1;
	logic [AW-1:0]      rd_addr;
	logic [ROW_W-1:0]   rd_row;
	logic signed [SAT_W-1:0] sat_l, sat_r;
	logic signed [SMP_W-1:0] res_l, res_r;
	spci_ctrl_t         ctrl;
	spci_prm_t          prm;

	// Handshakes
	assign bypass_w  = (ph_depth_q == '0) && (ch_depth_q == '0);
	assign in_stall  = (state_q != ST_IDLE) || clearing;
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign pos_adv   = (state_q == ST_CH_MIX) || ((state_q == ST_MIX) && !do_ch_q);

	// LFO mapping from the current phases
	assign tri_ph = tri_wave(ph_phase_q);
	assign tri_ch = tri_wave(ch_phase_q);
	assign cprod  = (2*TRI_W)'(COEF_SWEEP) * (2*TRI_W)'(tri_ph);
	assign dprod  = PHASE_W'(DLY_SWEEP) * PHASE_W'(tri_ch);
	assign coef_w = COEF_BASE + cprod[2*TRI_W-1:15];
	assign d8_w   = DLY_BASE + {1'b0, dprod[PHASE_W-1:15]};

	// Read position, one compare-subtract wrap over the 10.8 span
	assign rp_raw = {1'b0, pos_q, 8'h00} + RW'(SPAN) - RW'(d8_q);
	assign rp     = (rp_raw >= RW'(SPAN)) ? rp_raw - RW'(SPAN) : rp_raw;
	assign i1     = (i0_q == AW'(DELAY_FRAMES - 1)) ? '0 : i0_q + 1'b1;
	assign rd_addr = (state_q == ST_CH_RD) ? i1 : i0_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_depth_q <= '0;
			ch_depth_q <= '0;
			ph_step_q  <= PH_STEP_RST;
			ch_step_q  <= CH_STEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PH_DEPTH: ph_depth_q <= cfg_data[DEPTH_W-1:0];
				REG_CH_DEPTH: ch_depth_q <= cfg_data[DEPTH_W-1:0];
				REG_PH_STEP:  ph_step_q  <= cfg_data[PHASE_W-1:0];
				REG_CH_STEP:  ch_step_q  <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_accept) state_d = bypass_w ? ST_DONE : ST_SETUP;
			ST_SETUP:  state_d = do_ph_q ? ST_AP_A : ST_CH_WR;
			ST_AP_A:   state_d = ST_AP_B;
			ST_AP_B:   state_d = (stage_q == STG_W'(AP_STAGES - 1)) ? ST_MIX : ST_AP_A;
			ST_MIX:    state_d = do_ch_q ? ST_CH_WR : ST_DONE;
			ST_CH_WR:  state_d = ST_CH_RD;
			ST_CH_RD:  state_d = ST_CH_INT;
			ST_CH_INT: state_d = ST_CH_MIX;
			ST_CH_MIX: state_d = ST_DONE;
			ST_DONE:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control state: sequencer, LFO phases, write position, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_phase_q  <= '0;
			ch_phase_q  <= '0;
			pos_q       <= '0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept && !bypass_w) begin
				ph_phase_q <= ph_phase_q + ph_step_q;
				ch_phase_q <= ch_phase_q + ch_step_q;
			end
			if (pos_adv) begin
				pos_q <= (pos_q == AW'(DELAY_FRAMES - 1)) ? '0 : pos_q + 1'b1;
			end
			if (in_accept) begin
				stage_q <= '0;
			end else if (state_q == ST_AP_B) begin
				stage_q <= stage_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-frame values
	always_ff @(posedge clk) begin
		if (in_accept) begin
			bypass_q <= bypass_w;
			do_ph_q  <= ph_depth_q != '0;
			do_ch_q  <= ch_depth_q != '0;
			coef_q   <= coef_w;
			d8_q     <= d8_w;
		end
		if (state_q == ST_SETUP) begin
			i0_q   <= rp[AW+7:8];
			frac_q <= rp[7:0];
		end
		if (out_load) begin
			left_out_q  <= res_l;
			right_out_q <= res_r;
		end
	end

	// Lane controls
	always_comb begin
		ctrl.load  = in_accept;
		ctrl.ap_a  = state_q == ST_AP_A;
		ctrl.ap_b  = state_q == ST_AP_B;
		ctrl.mix   = state_q == ST_MIX;
		ctrl.tap0  = state_q == ST_CH_RD;
		ctrl.tap1  = state_q == ST_CH_INT;
		ctrl.chmix = state_q == ST_CH_MIX;
		ctrl.stage = stage_q;
		prm.bypass   = bypass_q;
		prm.coef     = coef_q;
		prm.ph_depth = ph_depth_q;
		prm.ch_depth = ch_depth_q;
		prm.frac     = frac_q;
	end

	spci_lane u_lane_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.prm       (prm),
		.sample_in (left_in),
		.tap_word  ($signed(rd_row[SAT_W-1:0])),
		.sat_out   (sat_l),
		.result    (res_l)
	);

	spci_lane u_lane_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.prm       (prm),
		.sample_in (right_in),
		.tap_word  ($signed(rd_row[ROW_W-1:SAT_W])),
		.sat_out   (sat_r),
		.result    (res_r)
	);

	// Merge: both clipped post-phaser samples form one delay row
	spci_delay #(
		.DEPTH (DELAY_FRAMES)
	) u_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (state_q == ST_CH_WR),
		.wr_addr  (pos_q),
		.wr_data  ({sat_r, sat_l}),
		.rd_addr  (rd_addr),
		.rd_data  (rd_row),
		.clearing (clearing)
	);

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// Checks
	`SPCI_ASSERT_IMPL(a_clear_blocks_input, clk, arst_n, clearing, in_stall, "frame taken during delay clear")
	`SPCI_ASSERT_IMPL(a_taps_miss_write_row, clk, arst_n, state_q == ST_CH_WR, (i0_q != pos_q) && (i1 != pos_q), "chorus tap reads the row being written")
	`SPCI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, state_q != ST_IDLE, "sequencer idle after a transaction")

endmodule

`default_nettype wire

### tb/sv/stereo_phaser_chorus_insert_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the phaser and chorus insert: frame predictor and output comparison.
module stereo_phaser_chorus_insert_scoreboard
	import spci_pkg::*;
#(
	parameter int LINE_FRAMES = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [SMP_W-1:0] left_in,
	input  logic signed [SMP_W-1:0] right_in,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [SMP_W-1:0] left_out,
	input  logic signed [SMP_W-1:0] right_out,
	output int                      mismatches,
	output int                      pending
);

	// LFO mapping and limits
	localparam longint COEF_MIN   = 4915;
	localparam longint COEF_SPAN  = 22938;
	localparam longint DLY_MIN    = 441;
	localparam longint DLY_SPAN   = 330;
	localparam longint TRI_TOP    = 32768;
	localparam longint TRI_FOLD   = 65535;
	localparam longint CLIP_HI    = 32767;
	localparam longint CLIP_LO    = -32768;
	localparam logic [PHASE_W-1:0] PH_STEP_INIT = 32'd197456;
	localparam logic [PHASE_W-1:0] CH_STEP_INIT = 32'd105068;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
	} stereo_t;

	// frames predicted but not yet seen at the output
	stereo_t processed_frames [$];

	// register copies
	logic [DEPTH_W-1:0] ph_depth_r, ch_depth_r;
	logic [PHASE_W-1:0] ph_step_r, ch_step_r;

	// effect state
	logic [PHASE_W-1:0]      ph_acc, ch_acc;
	int                      wr_ptr;
	longint                  ap_mem [2][AP_STAGES];
	logic signed [SAT_W-1:0] echo_line [2][LINE_FRAMES];

	int      fail_cnt, row, col;
	stereo_t got, want;

	// triangle LFO from the top 16 phase bits
	function automatic longint tri_wave(input logic [PHASE_W-1:0] ph);
		longint t;
		t = longint'(ph[31:16]);
		return (t < TRI_TOP) ? t : TRI_FOLD - t;
	endfunction

	// two's complement wrap of the all-pass memory word
	function automatic longint wrap32(input longint v);
		return longint'(signed'(v[31:0]));
	endfunction

	function automatic longint sat16(input longint v);
		if (v > CLIP_HI) return CLIP_HI;
		if (v < CLIP_LO) return CLIP_LO;
		return v;
	endfunction

	// one stereo frame through phaser and chorus, advancing the state
	function automatic stereo_t run_insert(input stereo_t fin);
		longint  smp [2];
		longint  res [2];
		longint  coef, d8, ph_mix, ch_mix, x, s, y, tap, rp, i0, i1, frac, span;
		int      pos;
		logic    on_ph, on_ch;
		stereo_t fout;
		on_ph = ph_depth_r != '0;
		on_ch = ch_depth_r != '0;
		// bypass: input returned as is, nothing moves
		if (!on_ph && !on_ch)
			return fin;
		smp[0] = longint'($signed(fin.left));
		smp[1] = longint'($signed(fin.right));
		ph_mix = longint'(ph_depth_r) << 7;
		ch_mix = longint'(ch_depth_r) << 7;
		coef = COEF_MIN + ((COEF_SPAN * tri_wave(ph_acc)) >>> 15);
		d8 = (DLY_MIN << 8) + (((DLY_SPAN << 8) * tri_wave(ch_acc)) >>> 15);
		span = longint'(LINE_FRAMES) << 8;
		pos = wr_ptr;
		for (int ch = 0; ch < 2; ch++) begin
			x = smp[ch];
			if (on_ph) begin
				s = x;
				for (int st = 0; st < AP_STAGES; st++) begin
					y = wrap32(ap_mem[ch][st] - ((coef * s) >>> 15));
					ap_mem[ch][st] = wrap32(s + ((coef * y) >>> 15));
					s = y;
				end
				x = x + (((s - x) * ph_mix) >>> 15);
			end
			if (on_ch) begin
				// line holds the clipped post-phaser signal
				echo_line[ch][pos] = SAT_W'(sat16(x));
				rp = (longint'(pos) * 256 + span - d8) % span;
				i0 = rp >> 8;
				frac = rp & 255;
				i1 = (i0 + 1) % LINE_FRAMES;
				tap = (longint'(echo_line[ch][i0]) * (256 - frac)
					+ longint'(echo_line[ch][i1]) * frac) >>> 8;
				x = x + ((tap * ch_mix) >>> 15);
			end
			res[ch] = sat16(x);
		end
		ph_acc = ph_acc + ph_step_r;
		ch_acc = ch_acc + ch_step_r;
		wr_ptr = (pos + 1) % LINE_FRAMES;
		fout.left = res[0][SMP_W-1:0];
		fout.right = res[1][SMP_W-1:0];
		return fout;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_depth_r = '0;
			ch_depth_r = '0;
			ph_step_r = PH_STEP_INIT;
			ch_step_r = CH_STEP_INIT;
			ph_acc = '0;
			ch_acc = '0;
			wr_ptr = 0;
			for (row = 0; row < 2; row++) begin
				for (col = 0; col < AP_STAGES; col++)
					ap_mem[row][col] = 0;
				for (col = 0; col < LINE_FRAMES; col++)
					echo_line[row][col] = '0;
			end
			processed_frames.delete();
			fail_cnt = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// register writes; unused indexes are dropped
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PH_DEPTH: ph_depth_r = cfg_data[DEPTH_W-1:0];
					REG_CH_DEPTH: ch_depth_r = cfg_data[DEPTH_W-1:0];
					REG_PH_STEP:  ph_step_r = cfg_data[PHASE_W-1:0];
					REG_CH_STEP:  ch_step_r = cfg_data[PHASE_W-1:0];
					default: ;
				endcase
			end
			// output transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				got.left = left_out;
				got.right = right_out;
				if (processed_frames.size() == 0) begin
					if (fail_cnt < REPORT_LIMIT)
						$display("%t: unexpected output frame L=%0d R=%0d", $realtime,
							got.left, got.right);
					fail_cnt++;
				end else begin
					want = processed_frames.pop_front();
					if (got.left !== want.left || got.right !== want.right) begin
						if (fail_cnt < REPORT_LIMIT)
							$display("%t: frame mismatch, expected L=%0d R=%0d, got L=%0d R=%0d",
								$realtime, want.left, want.right, got.left, got.right);
						fail_cnt++;
					end
				end
			end
			// input transaction
			if (in_valid && !in_stall)
				processed_frames.push_back(run_insert({left_in, right_in}));
			mismatches <= fail_cnt;
			pending <= processed_frames.size();
		end
	end

endmodule

### tb/sv/stereo_phaser_chorus_insert_test.sv
`timescale 1ns / 1ps
// Testbench top for the phaser and chorus insert: clock, reset, stimulus and verdict.
module stereo_phaser_chorus_insert_test import spci_pkg::*; ();

	localparam int LINE_FRAMES   = 1024;
	localparam int QUIET_LIMIT   = 20000;
	localparam int RANDOM_FRAMES = 1600;
	localparam int TAIL_CYCLES   = 40;
	localparam logic signed [SMP_W-1:0] SMP_MAX = SMP_W'(131071);
	localparam logic signed [SMP_W-1:0] SMP_MIN = SMP_W'(-131072);
	localparam logic signed [SMP_W-1:0] CLIP_HI = SMP_W'(32767);
	localparam logic signed [SMP_W-1:0] CLIP_LO = SMP_W'(-32768);
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd4;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [SMP_W-1:0] left_in, right_in;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [SMP_W-1:0] left_out, right_out;

	int mismatches, pending;
	int send_idle_pct, stall_pct;
	int frames_sent, settings_used, quiet;

	always #2 clk = ~clk;

	stereo_phaser_chorus_insert #(.DELAY_FRAMES(LINE_FRAMES)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_stall(out_stall), .left_out(left_out), .right_out(right_out)
	);

	stereo_phaser_chorus_insert_scoreboard #(.LINE_FRAMES(LINE_FRAMES)) board (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_stall(out_stall), .left_out(left_out), .right_out(right_out),
		.mismatches(mismatches), .pending(pending)
	);

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// register write, only while no frame is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one input transaction with optional idle cycles ahead of it
	task automatic send_frame(input logic signed [SMP_W-1:0] l, input logic signed [SMP_W-1:0] r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frames_sent++;
	endtask

	// stop sending and wait for every predicted frame to come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_extremes();
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame('1, '0);
		send_frame(CLIP_HI, CLIP_LO);
	endtask

	function automatic logic [DEPTH_W-1:0] pick_depth();
		case ($urandom_range(0, 3))
			0: return 8'd1;
			1: return 8'd255;
			default: return DEPTH_W'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [PHASE_W-1:0] pick_step();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return PHASE_W'($urandom_range(0, 1 << 20));
			default: return $urandom();
		endcase
	endfunction

	// mostly audio-range samples, some full-scale and near-zero
	function automatic logic signed [SMP_W-1:0] pick_sample();
		logic [15:0] v16;
		logic [7:0]  v8;
		v16 = 16'($urandom());
		v8 = 8'($urandom());
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
			1, 2: return SMP_W'($urandom());
			3: return {{10{v8[7]}}, v8};
			default: return {{2{v16[15]}}, v16};
		endcase
	endfunction

	// new random setting: bypass, phaser only, chorus only or both
	task automatic apply_settings();
		logic [DEPTH_W-1:0] pd, cd;
		case ($urandom_range(0, 9))
			0: begin
				pd = '0;
				cd = '0;
			end
			1: begin
				pd = pick_depth();
				cd = '0;
			end
			2: begin
				pd = '0;
				cd = pick_depth();
			end
			default: begin
				pd = pick_depth();
				cd = pick_depth();
			end
		endcase
		// upper data bits are junk that must be masked off
		write_reg(REG_PH_DEPTH, {24'($urandom()), pd});
		write_reg(REG_CH_DEPTH, {24'($urandom()), cd});
		write_reg(REG_PH_STEP, pick_step());
		write_reg(REG_CH_STEP, pick_step());
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 3)), $urandom());
		settings_used++;
	endtask

	initial begin
		int seg_len, phase_frames;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		frames_sent = 0;
		settings_used = 1;
		send_idle_pct = 7;
		stall_pct = 84;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: both depths zero, frames pass untouched
		send_extremes();
		settle();

		// phaser only, wide write data and an ignored index
		write_reg(REG_PH_DEPTH, 32'hABCD_12FF);
		write_reg(REG_FIRST_UNUSED, 32'h0000_0055);
		settings_used++;
		send_extremes();
		send_frame(0, 0);
		settle();

		// chorus only, LFO running backwards
		write_reg(REG_PH_DEPTH, 32'd0);
		write_reg(REG_CH_DEPTH, 32'd128);
		write_reg(REG_CH_STEP, '1);
		settings_used++;
		send_extremes();
		settle();

		// smallest depths, frozen LFOs
		write_reg(REG_PH_DEPTH, 32'd1);
		write_reg(REG_CH_DEPTH, 32'd1);
		write_reg(REG_PH_STEP, '0);
		write_reg(REG_CH_STEP, '0);
		settings_used++;
		send_extremes();
		settle();

		// full depths, chorus LFO jumping to the triangle peak
		write_reg(REG_PH_DEPTH, 32'd255);
		write_reg(REG_CH_DEPTH, 32'd255);
		write_reg(REG_PH_STEP, '1);
		write_reg(REG_CH_STEP, 32'h8000_0000);
		settings_used++;
		send_extremes();
		send_frame(SMP_MAX, SMP_MAX);
		settle();

		// random segments under three pacing modes
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 84 : 0;
			stall_pct = (mode == 0) ? 84 : (mode == 1) ? 7 : 0;
			phase_frames = 0;
			while (phase_frames < RANDOM_FRAMES / 3) begin
				apply_settings();
				seg_len = $urandom_range(40, 120);
				repeat (seg_len)
					send_frame(pick_sample(), pick_sample());
				settle();
				phase_frames += seg_len;
			end
		end

		// let any stray output show up
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d frames over %0d register settings: bypass, phaser, chorus and both,",
			frames_sent, settings_used);
		$display("with sender gaps, receiver stalls and full rate in turn; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
